/* design/psp_pkg.sv */
// shared types, constants and helpers for the packet send pacer
`default_nettype none

package psp_pkg;

    localparam int TIME_BITS     = 48;
    localparam int MODE_BITS     = 3;
    localparam int INFLIGHT_BITS = 32;
    localparam int DELAY_BITS    = 24;
    localparam int GRAN_BITS     = 20;
    localparam int TOKEN_BITS    = 8;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [TOKEN_BITS-1:0] REFILL_RESET = TOKEN_BITS'(10);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEND_SLACK   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_BURST_REFILL = CFG_IDX_BITS'(1);

    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_TICK_START  = 3'd0,
        MODE_TICK_END    = 3'd1,
        MODE_SEND_QUERY  = 3'd2,
        MODE_PKT_SENT    = 3'd3,
        MODE_LOSS        = 3'd4,
        MODE_PROBE_QUERY = 3'd5
    } mode_t;

    typedef struct packed {
        logic [GRAN_BITS-1:0]  send_slack;
        logic [TOKEN_BITS-1:0] burst_refill;
    } cfg_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]     mode;
        time_t                    now;
        logic [INFLIGHT_BITS-1:0] inflight;
        logic                     in_recovery;
        logic [DELAY_BITS-1:0]    tx_delay;
    } event_t;

    typedef struct packed {
        time_t                 current_time;
        time_t                 next_sched_time;
        time_t                 last_delayed_time;
        logic [TOKEN_BITS-1:0] burst_tokens;
        logic                  last_was_delayed;
        logic                  delayed_at_tick_start;
        logic                  sent_this_tick;
    } state_t;

    typedef struct packed {
        logic                  allowed;
        time_t                 next_send_time;
        logic [TOKEN_BITS-1:0] tokens_left;
        logic                  delayed;
    } result_t;

    // time add that sticks at the largest time value on overflow
    function automatic time_t tadd(input time_t a, input time_t b);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum[TIME_BITS])
        begin
            return {TIME_BITS{1'b1}};
        end
        return sum[TIME_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/psp_cfg.sv */
// configuration registers of the packet send pacer
`default_nettype none

module psp_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [psp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [psp_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output psp_pkg::cfg_t                          cfg
);
    import psp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SEND_SLACK:   cfg_next.send_slack   = cfg_data[GRAN_BITS-1:0];
                CFG_BURST_REFILL: cfg_next.burst_refill = cfg_data[TOKEN_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.send_slack   <= '0;
            cfg_reg.burst_refill <= REFILL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* design/psp_step.sv */
// event logic: next pacer state and result for one word
`default_nettype none

module psp_step (
    input  wire psp_pkg::cfg_t   cfg,
    input  wire psp_pkg::event_t ev,
    input  wire psp_pkg::state_t st,
    output psp_pkg::state_t      st_next,
    output psp_pkg::result_t     res
);
    import psp_pkg::*;

    logic                  idle;
    time_t                 delay;
    time_t                 gran;
    time_t                 half_delay;
    logic [TOKEN_BITS-1:0] tokens_eff;
    time_t                 sched_plus;
    time_t                 cur_plus;
    time_t                 ldt_plus;
    logic                  app_limited;
    logic                  making_up;
    logic                  allowed;

    always_comb
    begin
        idle        = (ev.inflight == '0);
        delay       = TIME_BITS'(ev.tx_delay);
        gran        = TIME_BITS'(cfg.send_slack);
        half_delay  = TIME_BITS'(ev.tx_delay >> 1);
        tokens_eff  = (idle && !ev.in_recovery) ? cfg.burst_refill : st.burst_tokens;
        sched_plus  = tadd(st.next_sched_time, delay);
        cur_plus    = tadd(st.current_time, delay);
        ldt_plus    = tadd(st.last_delayed_time, delay);
        app_limited = (st.last_delayed_time != '0) && (ldt_plus <= st.current_time);
        making_up   = (sched_plus <= st.current_time);
        allowed     = 1'b0;
        st_next     = st;

        case (mode_t'(ev.mode))
            MODE_TICK_START:
            begin
                if (ev.now >= st.current_time)
                begin
                    st_next.current_time = ev.now;
                end
                if (st.last_was_delayed)
                begin
                    st_next.delayed_at_tick_start = 1'b1;
                end
                st_next.sent_this_tick = 1'b0;
            end
            MODE_TICK_END:
            begin
                // drop a stale delayed mark when nothing went out this tick
                if (st.delayed_at_tick_start && !st.sent_this_tick &&
                    (st.current_time > st.next_sched_time))
                begin
                    st_next.last_was_delayed = 1'b0;
                end
                st_next.delayed_at_tick_start = 1'b0;
            end
            MODE_SEND_QUERY:
            begin
                if ((st.burst_tokens != '0) || idle)
                begin
                    allowed = 1'b1;
                end
                else if (st.next_sched_time > tadd(st.current_time, gran))
                begin
                    st_next.last_was_delayed = 1'b1;
                end
                else
                begin
                    allowed = 1'b1;
                end
            end
            MODE_PKT_SENT:
            begin
                st_next.sent_this_tick = 1'b1;
                st_next.burst_tokens   = tokens_eff;
                if (tokens_eff != '0)
                begin
                    st_next.burst_tokens      = tokens_eff - TOKEN_BITS'(1);
                    st_next.last_was_delayed  = 1'b0;
                    st_next.next_sched_time   = '0;
                    st_next.last_delayed_time = '0;
                end
                else if (st.last_was_delayed)
                begin
                    // catch up after a delayed send
                    st_next.next_sched_time = sched_plus;
                    if (app_limited || making_up)
                    begin
                        st_next.last_delayed_time = st.current_time;
                    end
                    else
                    begin
                        st_next.last_was_delayed  = 1'b0;
                        st_next.last_delayed_time = '0;
                    end
                end
                else
                begin
                    st_next.next_sched_time = (sched_plus > cur_plus) ? sched_plus : cur_plus;
                end
            end
            MODE_LOSS:
            begin
                st_next.burst_tokens = '0;
            end
            MODE_PROBE_QUERY:
            begin
                allowed = (st.burst_tokens > TOKEN_BITS'(1)) || idle ||
                          (st.next_sched_time > tadd(st.current_time, half_delay));
            end
            default:
            begin
                st_next = st;
            end
        endcase

        res.allowed        = allowed;
        res.next_send_time = st_next.next_sched_time;
        res.tokens_left    = st_next.burst_tokens;
        res.delayed        = st_next.last_was_delayed;
    end

endmodule

`default_nettype wire

/* design/packet_send_pacer.sv */
// top level of the packet send pacer: input register, event logic, result register
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  in       | in_valid / in_ready  | mode, now, inflight, in_recovery, tx_delay
//  out      | out_valid / out_ready| allowed, next_send_time, tokens_left, delayed
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one word per cycle sustained while out_ready is high; each word is held in the input register
// and is then applied to the pacer state, its result landing in the result register;
// the limit is the combinational state update loop
// reset clears the pacer state and config: times zero, tokens and refill ten
// a stalled result holds the result register, the input register holds its word,
// and in_ready drops only when both are full and out_ready is low
`default_nettype none

module packet_send_pacer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [psp_pkg::MODE_BITS-1:0]     mode,
    input  wire logic [psp_pkg::TIME_BITS-1:0]     now,
    input  wire logic [psp_pkg::INFLIGHT_BITS-1:0] inflight,
    input  wire logic                              in_recovery,
    input  wire logic [psp_pkg::DELAY_BITS-1:0]    tx_delay,

    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   allowed,
    output logic [psp_pkg::TIME_BITS-1:0]          next_send_time,
    output logic [psp_pkg::TOKEN_BITS-1:0]         tokens_left,
    output logic                                   delayed,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [psp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [psp_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import psp_pkg::*;

    cfg_t    cfg;

    // input register
    logic    ev_valid_reg;
    logic    ev_valid_next;
    event_t  ev_reg;

    // pacer state
    state_t  st_reg;
    state_t  st_next;

    // result register
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;
    result_t res_comb;

    logic    advance;
    logic    in_take;

    psp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psp_step u_step (
        .cfg     (cfg),
        .ev      (ev_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res_comb)
    );

    // the held word moves on when the result register is free or being drained
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !ev_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        ev_valid_next  = ev_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = ev_valid_reg;
            ev_valid_next  = 1'b0;
        end
        if (in_take)
        begin
            ev_valid_next = 1'b1;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg  <= ev_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // pacer state, updated once per applied word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.current_time          <= '0;
            st_reg.next_sched_time       <= '0;
            st_reg.last_delayed_time     <= '0;
            st_reg.burst_tokens          <= REFILL_RESET;
            st_reg.last_was_delayed      <= 1'b0;
            st_reg.delayed_at_tick_start <= 1'b0;
            st_reg.sent_this_tick        <= 1'b0;
        end
        else if (ev_valid_reg && advance)
        begin
            st_reg <= st_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ev_reg.mode        <= mode;
            ev_reg.now         <= now;
            ev_reg.inflight    <= inflight;
            ev_reg.in_recovery <= in_recovery;
            ev_reg.tx_delay    <= tx_delay;
        end
        if (ev_valid_reg && advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid      = out_valid_reg;
    assign allowed        = res_reg.allowed;
    assign next_send_time = res_reg.next_send_time;
    assign tokens_left    = res_reg.tokens_left;
    assign delayed        = res_reg.delayed;

endmodule

`default_nettype wire
